@@ hw/rtl/vertex_perspective_projection_defines.svh @@
// assertion macros shared by the projection pipeline
`ifndef VERTEX_PERSPECTIVE_PROJECTION_DEFINES_SVH
`define VERTEX_PERSPECTIVE_PROJECTION_DEFINES_SVH

// same-cycle implication
`define VPP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vpp same-cycle check failed");

// next-cycle implication
`define VPP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vpp next-cycle check failed");

`endif

@@ hw/rtl/vpp_pkg.sv @@
// shared types, widths and defaults of the vertex projection pipeline
`default_nettype none
package vpp_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int DEF_SCREEN_WIDTH  = 640;
    localparam int DEF_SCREEN_HEIGHT = 480;
    localparam int DEF_PIXEL_SCALE   = 512;
    localparam int DEF_NEAR_MILLI    = 10;
    localparam int DEF_RECIP_ENTRIES = 65536;

    localparam int CAM_W   = 33;
    localparam int RX_W    = 36;
    localparam int RY_W    = 39;
    localparam int DIST_W  = 42;
    localparam int DEPTH_W = 31;
    localparam int QUOT_W  = 27;
    localparam int RECIP_W = 26;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAM_X,
        CFG_CAM_Z,
        CFG_DIR_X,
        CFG_DIR_Z,
        CFG_EYE_HEIGHT,
        CFG_TILT_COS,
        CFG_TILT_SIN,
        CFG_LOOK_OFFSET
    } cfg_reg_t;

    typedef struct packed {
        logic signed [31:0] cam_x;
        logic signed [31:0] cam_z;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_z;
        logic signed [31:0] eye_height;
        logic signed [15:0] tilt_cos;
        logic signed [15:0] tilt_sin;
        logic signed [31:0] look_offset;
    } cfg_t;

    typedef struct packed {
        logic [15:0] shade;
        logic [15:0] tex_v;
        logic [15:0] tex_u;
    } attr_t;

    typedef struct packed {
        logic signed [RX_W-1:0] rot_x;
        logic signed [RY_W-1:0] rot_y;
        logic [DEPTH_W-1:0]     depth;
        attr_t                  attr;
    } side_t;

endpackage
`default_nettype wire

@@ hw/rtl/vpp_rotate.sv @@
// camera-space translation, yaw and pitch rotation, clamped view depth
`default_nettype none
module vpp_rotate #(
    parameter int NEAR_MILLI = vpp_pkg::DEF_NEAR_MILLI
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  vpp_pkg::cfg_t                    cfg,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [31:0]               vert_x,
    input  logic signed [31:0]               vert_y,
    input  logic signed [31:0]               vert_z,
    input  vpp_pkg::attr_t                   in_attr,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [vpp_pkg::RX_W-1:0]  rot_x,
    output logic signed [vpp_pkg::RY_W-1:0]  rot_y,
    output logic [vpp_pkg::DIST_W-1:0]       view_dist,
    output vpp_pkg::attr_t                   out_attr
);
    import vpp_pkg::*;

    localparam int NS     = 8;
    localparam int NEAR_Q = (NEAR_MILLI * 65536 + 999) / 1000;

    logic [NS-1:0] vld_reg;
    logic [NS:0]   adv;
    attr_t         attr_reg [NS];

    logic signed [CAM_W-1:0]  cx_reg, cz_reg, yr0_reg, yr1_reg, yr2_reg;
    logic signed [48:0]       pa_reg, pb_reg, pc_reg, pd_reg;
    logic signed [RX_W-1:0]   vz2_reg, vz3_reg, vz4_reg;
    logic signed [RX_W-1:0]   rx2_reg, rx3_reg, rx4_reg, rx5_reg, rx6_reg, rx7_reg;
    logic signed [48:0]       qa_reg;
    logic signed [51:0]       qb_reg, rb_reg;
    logic signed [RY_W-1:0]   ry4_reg, ry5_reg, ry6_reg, ry7_reg;
    logic signed [54:0]       ra_reg;
    logic signed [DIST_W-1:0] rz6_reg;
    logic [DIST_W-1:0]        dist7_reg;

    logic signed [49:0]       vz_sum, rx_sum;
    logic signed [52:0]       ry_sum;
    logic signed [55:0]       rz_sum;
    logic [DIST_W-1:0]        rz_abs;

    always_comb
    begin
        adv[NS] = out_ready;
        for (int i = NS - 1; i >= 0; i--)
        begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int i = 1; i < NS; i++)
            begin
                if (adv[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    always_comb
    begin
        vz_sum = pa_reg - pb_reg;
        rx_sum = pc_reg + pd_reg;
        ry_sum = qa_reg - qb_reg;
        rz_sum = ra_reg + rb_reg;
        rz_abs = rz6_reg[DIST_W-1] ? DIST_W'(-rz6_reg) : DIST_W'(rz6_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            cx_reg      <= CAM_W'(vert_x) - CAM_W'(cfg.cam_x);
            cz_reg      <= CAM_W'(vert_z) - CAM_W'(cfg.cam_z);
            yr0_reg     <= CAM_W'(vert_y) - CAM_W'(cfg.eye_height);
            attr_reg[0] <= in_attr;
        end
        if (adv[1])
        begin
            pa_reg  <= cz_reg * $signed(cfg.dir_x);
            pb_reg  <= cx_reg * $signed(cfg.dir_z);
            pc_reg  <= cx_reg * $signed(cfg.dir_x);
            pd_reg  <= cz_reg * $signed(cfg.dir_z);
            yr1_reg <= yr0_reg;
        end
        if (adv[2])
        begin
            vz2_reg <= vz_sum[49:14];
            rx2_reg <= rx_sum[49:14];
            yr2_reg <= yr1_reg;
        end
        if (adv[3])
        begin
            qa_reg  <= yr2_reg * $signed(cfg.tilt_cos);
            qb_reg  <= vz2_reg * $signed(cfg.tilt_sin);
            vz3_reg <= vz2_reg;
            rx3_reg <= rx2_reg;
        end
        if (adv[4])
        begin
            ry4_reg <= ry_sum[52:14];
            vz4_reg <= vz3_reg;
            rx4_reg <= rx3_reg;
        end
        if (adv[5])
        begin
            ra_reg  <= ry4_reg * $signed(cfg.tilt_sin);
            rb_reg  <= vz4_reg * $signed(cfg.tilt_cos);
            ry5_reg <= ry4_reg;
            rx5_reg <= rx4_reg;
        end
        if (adv[6])
        begin
            rz6_reg <= rz_sum[55:14];
            ry6_reg <= ry5_reg;
            rx6_reg <= rx5_reg;
        end
        if (adv[7])
        begin
            dist7_reg <= (rz_abs < DIST_W'(NEAR_Q)) ? DIST_W'(NEAR_Q) : rz_abs;
            ry7_reg   <= ry6_reg;
            rx7_reg   <= rx6_reg;
        end
        for (int i = 1; i < NS; i++)
        begin
            if (adv[i])
            begin
                attr_reg[i] <= attr_reg[i-1];
            end
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = vld_reg[NS-1];
    assign rot_x     = rx7_reg;
    assign rot_y     = ry7_reg;
    assign view_dist = dist7_reg;
    assign out_attr  = attr_reg[NS-1];

endmodule
`default_nettype wire

@@ hw/rtl/vpp_recip.sv @@
// depth quantisation and pipelined reciprocal divider
`default_nettype none
module vpp_recip #(
    parameter int RECIP_ENTRIES = vpp_pkg::DEF_RECIP_ENTRIES
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [vpp_pkg::RX_W-1:0]   rot_x,
    input  logic signed [vpp_pkg::RY_W-1:0]   rot_y,
    input  logic [vpp_pkg::DIST_W-1:0]        view_dist,
    input  vpp_pkg::attr_t                    in_attr,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [vpp_pkg::RECIP_W-1:0]       recip,
    output vpp_pkg::side_t                    out_side
);
    import vpp_pkg::*;

    localparam int IW    = $clog2(RECIP_ENTRIES);
    localparam int DB    = 4;
    localparam int DS    = (QUOT_W + DB - 1) / DB;
    localparam int NR    = DS + 3;
    localparam int MUL_W = DIST_W + 10;
    localparam int TQ_W  = MUL_W - 16;
    localparam logic [QUOT_W-1:0] DIVIDEND = QUOT_W'(131072000);

    logic [NR-1:0] vld_reg;
    logic [NR:0]   adv;
    side_t         side_reg [NR];

    logic [MUL_W-1:0]   mul_reg;
    logic [IW-1:0]      idx_reg;
    logic [IW-1:0]      rem_reg [DS];
    logic [IW-1:0]      d_reg   [DS];
    logic [QUOT_W-1:0]  q_reg   [DS];
    logic [RECIP_W-1:0] recip_reg;

    logic [IW-1:0]      rem_next [DS];
    logic [IW-1:0]      d_next   [DS];
    logic [QUOT_W-1:0]  q_next   [DS];
    logic [TQ_W-1:0]    tq;
    logic [IW-1:0]      idx_next;
    logic [DEPTH_W-1:0] depth_next;
    logic [QUOT_W:0]    q_round;

    always_comb
    begin
        adv[NR] = out_ready;
        for (int i = NR - 1; i >= 0; i--)
        begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int i = 1; i < NR; i++)
            begin
                if (adv[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    always_comb
    begin
        depth_next = (view_dist > DIST_W'(32'h7FFF_FFFF)) ? DEPTH_W'(31'h7FFF_FFFF)
                                                          : view_dist[DEPTH_W-1:0];
        tq = mul_reg[MUL_W-1:16];
        if (tq > TQ_W'(RECIP_ENTRIES - 1))
        begin
            idx_next = IW'(RECIP_ENTRIES - 1);
        end
        else if (tq == '0)
        begin
            idx_next = IW'(1);
        end
        else
        begin
            idx_next = tq[IW-1:0];
        end
        q_round = {1'b0, q_reg[DS-1]} + (QUOT_W + 1)'(1);
    end

    // restoring division, DB quotient bits per stage
    always_comb
    begin
        logic [IW-1:0]     r;
        logic [IW-1:0]     d;
        logic [QUOT_W-1:0] q;
        logic [IW:0]       t;
        int                k;
        for (int j = 0; j < DS; j++)
        begin
            if (j == 0)
            begin
                r = '0;
                q = '0;
                d = idx_reg;
            end
            else
            begin
                r = rem_reg[j-1];
                q = q_reg[j-1];
                d = d_reg[j-1];
            end
            for (int b = 0; b < DB; b++)
            begin
                k = QUOT_W - 1 - j * DB - b;
                t = '0;
                if (k >= 0)
                begin
                    t = {r, DIVIDEND[k]};
                    if (t >= {1'b0, d})
                    begin
                        t    = t - {1'b0, d};
                        q[k] = 1'b1;
                    end
                    r = t[IW-1:0];
                end
            end
            rem_next[j] = r;
            q_next[j]   = q;
            d_next[j]   = d;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            mul_reg           <= MUL_W'(view_dist) * MUL_W'(1000);
            side_reg[0].rot_x <= rot_x;
            side_reg[0].rot_y <= rot_y;
            side_reg[0].depth <= depth_next;
            side_reg[0].attr  <= in_attr;
        end
        if (adv[1])
        begin
            idx_reg <= idx_next;
        end
        for (int j = 0; j < DS; j++)
        begin
            if (adv[2+j])
            begin
                rem_reg[j] <= rem_next[j];
                q_reg[j]   <= q_next[j];
                d_reg[j]   <= d_next[j];
            end
        end
        if (adv[NR-1])
        begin
            recip_reg <= q_round[RECIP_W:1];
        end
        for (int i = 1; i < NR; i++)
        begin
            if (adv[i])
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = vld_reg[NR-1];
    assign recip     = recip_reg;
    assign out_side  = side_reg[NR-1];

endmodule
`default_nettype wire

@@ hw/rtl/vpp_project.sv @@
// perspective scaling, screen centring, rounding and saturation
`default_nettype none
module vpp_project #(
    parameter int SCREEN_WIDTH  = vpp_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = vpp_pkg::DEF_SCREEN_HEIGHT,
    parameter int PIXEL_SCALE   = vpp_pkg::DEF_PIXEL_SCALE
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic signed [31:0]              look_offset,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [vpp_pkg::RECIP_W-1:0]     recip,
    input  vpp_pkg::side_t                  in_side,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [15:0]              screen_x,
    output logic signed [15:0]              screen_y,
    output logic [vpp_pkg::DEPTH_W-1:0]     depth,
    output vpp_pkg::attr_t                  out_attr
);
    import vpp_pkg::*;

    localparam int NP   = 4;
    localparam int LO_W = 14;
    localparam int HI_W = RECIP_W - LO_W;
    localparam int FX_W = RX_W + RECIP_W + 1 - 16;
    localparam int FY_W = RY_W + RECIP_W + 1 - 16;
    localparam int SX_W = FX_W + 15;
    localparam int SY_W = FY_W + 15;
    localparam int PX_W = SX_W + 2;
    localparam int PY_W = SY_W + 2;
    localparam logic [13:0] SCALE_U = 14'(PIXEL_SCALE);
    localparam int CX_OFF = SCREEN_WIDTH * 32768 + 32768;
    localparam int CY_OFF = SCREEN_HEIGHT * 32768 + 32768;

    logic [NP-1:0] vld_reg;
    logic [NP:0]   adv;
    logic [DEPTH_W-1:0] depth_reg [NP];
    attr_t              attr_reg  [NP];

    logic signed [RX_W+LO_W:0] xl_reg;
    logic signed [RX_W+HI_W:0] xh_reg;
    logic signed [RY_W+LO_W:0] yl_reg;
    logic signed [RY_W+HI_W:0] yh_reg;
    logic signed [FX_W-1:0]    fx_reg;
    logic signed [FY_W-1:0]    fy_reg;
    logic signed [SX_W-1:0]    sx_reg;
    logic signed [SY_W-1:0]    sy_reg;
    logic signed [15:0]        scr_x_reg, scr_y_reg;

    logic signed [FX_W+15:0]   full_x;
    logic signed [FY_W+15:0]   full_y;
    logic signed [PX_W-1:0]    px;
    logic signed [PY_W-1:0]    py;

    function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
        if (v > 64'sd32767)
        begin
            return 16'sh7FFF;
        end
        if (v < -64'sd32768)
        begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    always_comb
    begin
        adv[NP] = out_ready;
        for (int i = NP - 1; i >= 0; i--)
        begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int i = 1; i < NP; i++)
            begin
                if (adv[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    always_comb
    begin
        full_x = ((FX_W + 16)'(xh_reg) <<< LO_W) + (FX_W + 16)'(xl_reg);
        full_y = ((FY_W + 16)'(yh_reg) <<< LO_W) + (FY_W + 16)'(yl_reg);
        px = PX_W'(CX_OFF) - PX_W'(sx_reg);
        py = PY_W'(CY_OFF) - PY_W'(sy_reg) + PY_W'(look_offset);
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            xl_reg       <= in_side.rot_x * $signed({1'b0, recip[LO_W-1:0]});
            xh_reg       <= in_side.rot_x * $signed({1'b0, recip[RECIP_W-1:LO_W]});
            yl_reg       <= in_side.rot_y * $signed({1'b0, recip[LO_W-1:0]});
            yh_reg       <= in_side.rot_y * $signed({1'b0, recip[RECIP_W-1:LO_W]});
            depth_reg[0] <= in_side.depth;
            attr_reg[0]  <= in_side.attr;
        end
        if (adv[1])
        begin
            fx_reg <= full_x[FX_W+15:16];
            fy_reg <= full_y[FY_W+15:16];
        end
        if (adv[2])
        begin
            sx_reg <= fx_reg * $signed({1'b0, SCALE_U});
            sy_reg <= fy_reg * $signed({1'b0, SCALE_U});
        end
        if (adv[3])
        begin
            scr_x_reg <= sat16(64'($signed(px[PX_W-1:16])));
            scr_y_reg <= sat16(64'($signed(py[PY_W-1:16])));
        end
        for (int i = 1; i < NP; i++)
        begin
            if (adv[i])
            begin
                depth_reg[i] <= depth_reg[i-1];
                attr_reg[i]  <= attr_reg[i-1];
            end
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = vld_reg[NP-1];
    assign screen_x  = scr_x_reg;
    assign screen_y  = scr_y_reg;
    assign depth     = depth_reg[NP-1];
    assign out_attr  = attr_reg[NP-1];

endmodule
`default_nettype wire

@@ hw/rtl/vertex_perspective_projection.sv @@
// top level of the vertex perspective projection pipeline
`default_nettype none
// Projects one world-space vertex per clock to screen coordinates for a
// yaw/pitch camera held in configuration registers. Throughput is one item
// per cycle while the result is taken. There are 8 rotation stages, 10
// stages for depth quantisation and the reciprocal divider which resolves
// four quotient bits per stage, and 4 projection stages. Every stage holds
// when the stage after it is full, so bubbles close up under back-pressure
// and the input is only held off when the whole pipe is full and the result
// is not taken. Configuration must be written through the plain write port
// only while the pipe is empty; the block itself does not enforce this.
module vertex_perspective_projection #(
    parameter int SCREEN_WIDTH  = vpp_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = vpp_pkg::DEF_SCREEN_HEIGHT,
    parameter int PIXEL_SCALE   = vpp_pkg::DEF_PIXEL_SCALE,
    parameter int NEAR_MILLI    = vpp_pkg::DEF_NEAR_MILLI,
    parameter int RECIP_ENTRIES = vpp_pkg::DEF_RECIP_ENTRIES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [vpp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [vpp_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // vert_x, vert_y, vert_z, tex_u, tex_v, shade
    input  logic [143:0]                    s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // screen_x, screen_y, depth, out_u, out_v, out_shade, zero pad
    output logic [111:0]                    m_tdata
);
    import vpp_pkg::*;

    `include "vertex_perspective_projection_defines.svh"

    localparam int NEAR_Q = (NEAR_MILLI * 65536 + 999) / 1000;

    cfg_t cfg_reg;

    logic                     rot_valid, rot_ready;
    logic signed [RX_W-1:0]   rot_x;
    logic signed [RY_W-1:0]   rot_y;
    logic [DIST_W-1:0]        rot_dist;
    attr_t                    in_attr, rot_attr, out_attr;
    logic                     rcp_valid, rcp_ready;
    logic [RECIP_W-1:0]       rcp_recip;
    side_t                    rcp_side;
    logic signed [15:0]       screen_x, screen_y;
    logic [DEPTH_W-1:0]       depth;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cam_x       <= '0;
            cfg_reg.cam_z       <= '0;
            cfg_reg.dir_x       <= 16'sd16384;
            cfg_reg.dir_z       <= '0;
            cfg_reg.eye_height  <= '0;
            cfg_reg.tilt_cos    <= 16'sd16384;
            cfg_reg.tilt_sin    <= '0;
            cfg_reg.look_offset <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_CAM_X:       cfg_reg.cam_x       <= cfg_data;
                CFG_CAM_Z:       cfg_reg.cam_z       <= cfg_data;
                CFG_DIR_X:       cfg_reg.dir_x       <= cfg_data[15:0];
                CFG_DIR_Z:       cfg_reg.dir_z       <= cfg_data[15:0];
                CFG_EYE_HEIGHT:  cfg_reg.eye_height  <= cfg_data;
                CFG_TILT_COS:    cfg_reg.tilt_cos    <= cfg_data[15:0];
                CFG_TILT_SIN:    cfg_reg.tilt_sin    <= cfg_data[15:0];
                CFG_LOOK_OFFSET: cfg_reg.look_offset <= cfg_data;
                default: ;
            endcase
        end
    end

    assign in_attr.tex_u = s_tdata[111:96];
    assign in_attr.tex_v = s_tdata[127:112];
    assign in_attr.shade = s_tdata[143:128];

    vpp_rotate #(
        .NEAR_MILLI (NEAR_MILLI)
    ) u_rotate (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .vert_x    (s_tdata[31:0]),
        .vert_y    (s_tdata[63:32]),
        .vert_z    (s_tdata[95:64]),
        .in_attr   (in_attr),
        .out_valid (rot_valid),
        .out_ready (rot_ready),
        .rot_x     (rot_x),
        .rot_y     (rot_y),
        .view_dist (rot_dist),
        .out_attr  (rot_attr)
    );

    vpp_recip #(
        .RECIP_ENTRIES (RECIP_ENTRIES)
    ) u_recip (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rot_valid),
        .in_ready  (rot_ready),
        .rot_x     (rot_x),
        .rot_y     (rot_y),
        .view_dist (rot_dist),
        .in_attr   (rot_attr),
        .out_valid (rcp_valid),
        .out_ready (rcp_ready),
        .recip     (rcp_recip),
        .out_side  (rcp_side)
    );

    vpp_project #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .PIXEL_SCALE   (PIXEL_SCALE)
    ) u_project (
        .clk         (clk),
        .rst_n       (rst_n),
        .look_offset (cfg_reg.look_offset),
        .in_valid    (rcp_valid),
        .in_ready    (rcp_ready),
        .recip       (rcp_recip),
        .in_side     (rcp_side),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .screen_x    (screen_x),
        .screen_y    (screen_y),
        .depth       (depth),
        .out_attr    (out_attr)
    );

    assign m_tdata = {1'b0, out_attr.shade, out_attr.tex_v, out_attr.tex_u,
                      depth, screen_y, screen_x};

    `VPP_ASSERT_IMPL(a_depth_floor, clk, rst_n, m_tvalid, m_tdata[62:32] >= DEPTH_W'(NEAR_Q))
    `VPP_ASSERT_IMPL(a_stall_cause, clk, rst_n, !s_tready, m_tvalid && !m_tready)
    `VPP_ASSERT_IMPL(a_recip_nonzero, clk, rst_n, rcp_valid, rcp_recip != '0)
    `VPP_ASSERT_NEXT(a_rot_hold, clk, rst_n, rot_valid && !rot_ready, rot_valid)

endmodule
`default_nettype wire

@@ tb/tb_vertex_perspective_projection.sv @@
// self-checking testbench for the vertex perspective projection pipeline
`default_nettype none
module tb_vertex_perspective_projection;
    timeunit 1ns;
    timeprecision 1ps;
    import vpp_pkg::*;

    localparam int LATENCY = 22;

    typedef struct packed {
        logic [15:0] shade;
        logic [15:0] tex_v;
        logic [15:0] tex_u;
        logic signed [31:0] vz;
        logic signed [31:0] vy;
        logic signed [31:0] vx;
    } vertex_t;

    typedef struct packed {
        logic [15:0] shade;
        logic [15:0] v;
        logic [15:0] u;
        logic [30:0] depth;
        logic signed [15:0] sy;
        logic signed [15:0] sx;
    } pixel_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [143:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [111:0] m_tdata;

    vertex_perspective_projection dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // camera copy
    longint c_cam_x = 0, c_cam_z = 0, c_dir_x = 16384, c_dir_z = 0;
    longint c_eye = 0, c_pcos = 16384, c_psin = 0, c_look = 0;

    vertex_t pending_verts[$];
    pixel_t expected_pixels[$];
    int sender_idle = 0;
    int receiver_stall = 0;
    int errors = 0;
    int pixels_seen = 0;
    int settings_used = 0;

    function automatic longint floor_shift(longint x, int n);
        return x >>> n;
    endfunction

    function automatic logic [15:0] clamp16(longint v);
        if (v > 32767)
            return 16'sd32767;
        if (v < -32768)
            return 16'h8000;
        return v[15:0];
    endfunction

    function automatic pixel_t project_vertex(vertex_t vt);
        pixel_t p;
        longint cx, cz, yr, vz, rx, ry, rz, nearq, vdist, idx, recip, sx, sy, px, py;
        cx = longint'(vt.vx) - c_cam_x;
        yr = longint'(vt.vy) - c_eye;
        cz = longint'(vt.vz) - c_cam_z;
        vz = floor_shift(cz * c_dir_x - cx * c_dir_z, 14);
        rx = floor_shift(cx * c_dir_x + cz * c_dir_z, 14);
        ry = floor_shift(yr * c_pcos - vz * c_psin, 14);
        rz = floor_shift(ry * c_psin + vz * c_pcos, 14);
        nearq = (10 * 65536 + 999) / 1000;
        vdist = rz < 0 ? -rz : rz;
        if (vdist < nearq)
            vdist = nearq;
        idx = (vdist * 1000) >>> 16;
        if (idx > 65535)
            idx = 65535;
        if (idx < 1)
            idx = 1;
        recip = (2 * 64'sd65536000 / idx + 1) / 2;
        sx = floor_shift(rx * recip, 16) * 512;
        sy = floor_shift(ry * recip, 16) * 512;
        px = 640 * 64'sd32768 - sx + 32768;
        py = 480 * 64'sd32768 - sy + c_look + 32768;
        p.sx = clamp16(floor_shift(px, 16));
        p.sy = clamp16(floor_shift(py, 16));
        p.depth = vdist > 64'h7FFFFFFF ? 31'h7FFFFFFF : vdist[30:0];
        p.u = vt.tex_u;
        p.v = vt.tex_v;
        p.shade = vt.shade;
        return p;
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!s_tvalid || s_tready)
            begin
                if (pending_verts.size() > 0 && $urandom_range(99) >= sender_idle)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata <= pending_verts.pop_front();
                end
                else
                    s_tvalid <= 1'b0;
            end
            m_tready <= $urandom_range(99) >= receiver_stall;
        end
    end

    // monitor and predictor
    always @(posedge clk)
    begin
        pixel_t got, want;
        if (rst_n && s_tvalid && s_tready)
            expected_pixels.push_back(project_vertex(vertex_t'(s_tdata)));
        if (rst_n && m_tvalid && m_tready)
        begin
            got = pixel_t'(m_tdata[110:0]);
            pixels_seen++;
            if (expected_pixels.size() == 0)
            begin
                $error("unexpected item %h", m_tdata);
                errors++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (got.sx !== want.sx)
                begin
                    $error("screen_x expected %0d got %0d", want.sx, got.sx);
                    errors++;
                end
                if (got.sy !== want.sy)
                begin
                    $error("screen_y expected %0d got %0d", want.sy, got.sy);
                    errors++;
                end
                if (got.depth !== want.depth)
                begin
                    $error("depth expected %0h got %0h", want.depth, got.depth);
                    errors++;
                end
                if (got.u !== want.u)
                begin
                    $error("out_u expected %0h got %0h", want.u, got.u);
                    errors++;
                end
                if (got.v !== want.v)
                begin
                    $error("out_v expected %0h got %0h", want.v, got.v);
                    errors++;
                end
                if (got.shade !== want.shade)
                begin
                    $error("out_shade expected %0h got %0h", want.shade, got.shade);
                    errors++;
                end
            end
        end
    end

    task automatic write_reg(cfg_reg_t r, logic [31:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= r;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (r)
            CFG_CAM_X: c_cam_x = longint'(signed'(val));
            CFG_CAM_Z: c_cam_z = longint'(signed'(val));
            CFG_DIR_X: c_dir_x = longint'(signed'(val[15:0]));
            CFG_DIR_Z: c_dir_z = longint'(signed'(val[15:0]));
            CFG_EYE_HEIGHT: c_eye = longint'(signed'(val));
            CFG_TILT_COS: c_pcos = longint'(signed'(val[15:0]));
            CFG_TILT_SIN: c_psin = longint'(signed'(val[15:0]));
            default: c_look = longint'(signed'(val));
        endcase
    endtask

    task automatic wait_drained();
        while (pending_verts.size() > 0 || s_tvalid || expected_pixels.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_coord(int mode);
        case (mode)
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return $urandom;
            default: return $urandom_range(0, 32'h00400000) - 32'h00200000;
        endcase
    endfunction

    task automatic add_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        vertex_t vt;
        vt.vx = x;
        vt.vy = y;
        vt.vz = z;
        vt.tex_u = $urandom;
        vt.tex_v = $urandom;
        vt.shade = $urandom;
        pending_verts.push_back(vt);
    endtask

    task automatic random_camera(int kind);
        write_reg(CFG_CAM_X, kind == 0 ? 32'h80000000 : pick_coord(kind % 4));
        write_reg(CFG_CAM_Z, kind == 0 ? 32'h7FFFFFFF : pick_coord((kind + 1) % 4));
        write_reg(CFG_DIR_X, kind == 1 ? 32'h8000 : $urandom_range(0, 32768) - 16384);
        write_reg(CFG_DIR_Z, kind == 1 ? 32'h7FFF : $urandom_range(0, 32768) - 16384);
        write_reg(CFG_EYE_HEIGHT, pick_coord(kind % 4));
        write_reg(CFG_TILT_COS, kind == 2 ? 32'hFFFF : $urandom_range(0, 32768) - 16384);
        write_reg(CFG_TILT_SIN, kind == 2 ? 32'h4000 : $urandom_range(0, 32768) - 16384);
        write_reg(CFG_LOOK_OFFSET, pick_coord((kind + 2) % 4));
        settings_used++;
    endtask

    initial
    begin
        int phase;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: default camera, extremes, near plane, far depth
        add_vertex(32'h0, 32'h0, 32'h0);
        add_vertex(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        add_vertex(32'h80000000, 32'h80000000, 32'h80000000);
        add_vertex(32'h00010000, 32'h00010000, 32'h00000100);
        add_vertex(32'h00010000, 32'hFFFF0000, 32'hFFFFFF00);
        add_vertex(32'h00001000, 32'h00000800, 32'h00010000);
        add_vertex(32'h7FFFFFFF, 32'h80000000, 32'h00000001);
        add_vertex(32'h80000000, 32'h7FFFFFFF, 32'h00000001);
        add_vertex(32'h0, 32'h0, 32'h7FFFFFFF);
        add_vertex(32'h0, 32'h0, 32'h80000000);
        add_vertex(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        add_vertex(32'h00640000, 32'h00320000, 32'h00C80000);
        wait_drained();
        // extreme camera settings, all registers
        for (int k = 0; k < 3; k++)
        begin
            random_camera(k);
            add_vertex(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
            add_vertex(32'h80000000, 32'h7FFFFFFF, 32'h80000000);
            add_vertex($urandom, $urandom, $urandom);
            wait_drained();
        end

        // random phases with differing idling
        for (phase = 0; phase < 8; phase++)
        begin
            case (phase % 4)
                0: begin sender_idle = 0;  receiver_stall = 0;  end
                1: begin sender_idle = 69; receiver_stall = 0;  end
                2: begin sender_idle = 0;  receiver_stall = 69; end
                default: begin sender_idle = 15; receiver_stall = 15; end
            endcase
            if (phase > 0)
                random_camera(3 + phase);
            for (int i = 0; i < 170; i++)
                add_vertex(pick_coord($urandom_range(3) == 0 ? $urandom_range(2) : 3),
                           pick_coord($urandom_range(3) == 0 ? $urandom_range(2) : 3),
                           pick_coord($urandom_range(3) == 0 ? $urandom_range(2) : 3));
            wait_drained();
        end

        $display("covered %0d projected vertices over %0d camera settings", pixels_seen,
                 settings_used + 1);
        $display("with idle and stall mixes on both stream sides");
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("timeout");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire
